>>> rtl/sbox_rotate_block_cipher_top_defines.svh
// assertion macros for the substitution-rotation cipher block
`ifndef SBOX_ROTATE_BLOCK_CIPHER_TOP_DEFINES_SVH
`define SBOX_ROTATE_BLOCK_CIPHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check on every clock edge outside reset
`define SRBC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// check on every clock edge, reset included
`define SRBC_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define SRBC_ASSERT_RST(label, prop, msg)
`define SRBC_ASSERT_ANY(label, prop, msg)
`endif

`endif

>>> rtl/srbc_pkg.sv
// shared types and constants of the substitution-rotation cipher block
`timescale 1ns / 1ps

package srbc_pkg;

    localparam int BLOCK_W     = 64;
    localparam int BYTE_W      = 8;
    localparam int LANES       = BLOCK_W / BYTE_W;
    localparam int SEL_W       = 3;
    localparam int TABLE_DEPTH = 256;
    localparam int ROUND_COUNT = 16;
    localparam int ROUND_W     = $clog2(ROUND_COUNT + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    // request codes on the input channel
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_ENC  = 2'd1;
    localparam logic [1:0] REQ_DEC  = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ENC,
        OP_DEC
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } st_t;

    typedef struct packed {
        op_t                op;
        logic [SEL_W-1:0]   sel;
        logic [BYTE_W-1:0]  idx;
        logic [BYTE_W-1:0]  val;
        logic [BLOCK_W-1:0] blk;
    } q_item_t;

    typedef struct packed {
        logic               not_empty;
        logic               full;
        logic [LEVEL_W-1:0] level;
    } q_stat_t;

    typedef struct packed {
        logic pop;
        logic done;
    } eng_stat_t;

endpackage

>>> rtl/srbc_front.sv
// front end: accepts items, classifies the request and feeds the queue
`timescale 1ns / 1ps

module srbc_front (
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_req_type,
    input  logic [srbc_pkg::SEL_W-1:0]       s_table_select,
    input  logic [srbc_pkg::BYTE_W-1:0]      s_entry_index,
    input  logic [srbc_pkg::BYTE_W-1:0]      s_entry_value,
    input  logic [srbc_pkg::BLOCK_W-1:0]     s_data_block,
    input  srbc_pkg::q_stat_t                q_stat,
    output logic                             q_push,
    output srbc_pkg::q_item_t                q_item
);

    // accept whenever the queue has room
    assign s_ready = !q_stat.full;

    // map request code to operation, unused code is dropped
    always_comb begin
        q_item.sel = s_table_select;
        q_item.idx = s_entry_index;
        q_item.val = s_entry_value;
        q_item.blk = s_data_block;
        q_item.op  = srbc_pkg::OP_LOAD;
        q_push     = 1'b0;
        case (s_req_type)
            srbc_pkg::REQ_LOAD: begin
                q_item.op = srbc_pkg::OP_LOAD;
                q_push    = s_valid && s_ready;
            end
            srbc_pkg::REQ_ENC: begin
                q_item.op = srbc_pkg::OP_ENC;
                q_push    = s_valid && s_ready;
            end
            srbc_pkg::REQ_DEC: begin
                q_item.op = srbc_pkg::OP_DEC;
                q_push    = s_valid && s_ready;
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/srbc_queue.sv
// short item queue between front end and cipher engine
`timescale 1ns / 1ps

module srbc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  srbc_pkg::q_item_t push_item,
    input  logic              pop,
    output srbc_pkg::q_item_t head,
    output srbc_pkg::q_stat_t stat
);

    srbc_pkg::q_item_t                   slot_reg [srbc_pkg::QUEUE_DEPTH];
    logic [srbc_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [srbc_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [srbc_pkg::LEVEL_W-1:0]        level_reg, level_next;

    // pointer and fill level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            if (wr_ptr_reg == srbc_pkg::QPTR_W'(srbc_pkg::QUEUE_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (pop) begin
            if (rd_ptr_reg == srbc_pkg::QPTR_W'(srbc_pkg::QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // item storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head           = slot_reg[rd_ptr_reg];
    assign stat.not_empty = (level_reg != '0);
    assign stat.full      = (level_reg == srbc_pkg::LEVEL_W'(srbc_pkg::QUEUE_DEPTH));
    assign stat.level     = level_reg;

endmodule

>>> rtl/srbc_engine.sv
// cipher engine: table memories, round loop and result register
`timescale 1ns / 1ps

module srbc_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [srbc_pkg::BLOCK_W-1:0]  key,
    input  srbc_pkg::q_item_t             head,
    input  srbc_pkg::q_stat_t             q_stat,
    output srbc_pkg::eng_stat_t           stat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [srbc_pkg::BLOCK_W-1:0]  m_result_block,
    output logic                          m_result_was_decrypt
);

    srbc_pkg::st_t                        state_reg, state_next;
    logic [srbc_pkg::ROUND_W-1:0]         cnt_reg, cnt_next;
    logic                                 dec_reg, dec_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [srbc_pkg::BLOCK_W-1:0]         out_block_reg;
    logic                                 out_dec_reg;

    logic                                 pop;
    logic                                 tbl_we;
    logic                                 rd_en;
    logic                                 load_out;
    logic [srbc_pkg::BLOCK_W-1:0]         fwd_word;
    logic [srbc_pkg::BLOCK_W-1:0]         inv_word;
    logic [srbc_pkg::BLOCK_W-1:0]         cur_blk;
    logic [srbc_pkg::BLOCK_W-1:0]         cur_rotr;

    // current block: incoming item at start, else the last round's output
    always_comb begin
        if (state_reg == srbc_pkg::ST_IDLE) begin
            cur_blk = head.blk;
        end else if (dec_reg) begin
            cur_blk = inv_word ^ key;
        end else begin
            cur_blk = {fwd_word[srbc_pkg::BLOCK_W-2:0], fwd_word[srbc_pkg::BLOCK_W-1]};
        end
    end

    assign cur_rotr = {cur_blk[0], cur_blk[srbc_pkg::BLOCK_W-1:1]};

    // one forward and one inverse table per byte lane
    for (genvar l = 0; l < srbc_pkg::LANES; l++) begin : g_lane
        localparam int Hi = srbc_pkg::BLOCK_W - 1 - srbc_pkg::BYTE_W * l;

        logic [srbc_pkg::BYTE_W-1:0] fwd_mem [srbc_pkg::TABLE_DEPTH];
        logic [srbc_pkg::BYTE_W-1:0] inv_mem [srbc_pkg::TABLE_DEPTH];
        logic [srbc_pkg::BYTE_W-1:0] fwd_q_reg;
        logic [srbc_pkg::BYTE_W-1:0] inv_q_reg;
        logic                        lane_we;
        logic [srbc_pkg::BYTE_W-1:0] fwd_addr;
        logic [srbc_pkg::BYTE_W-1:0] inv_addr;

        assign lane_we  = tbl_we && (head.sel == srbc_pkg::SEL_W'(l));
        assign fwd_addr = cur_blk[Hi -: srbc_pkg::BYTE_W] ^ key[Hi -: srbc_pkg::BYTE_W];
        assign inv_addr = cur_rotr[Hi -: srbc_pkg::BYTE_W];

        // forward table: written by loads, read during encrypt
        always_ff @(posedge aclk) begin
            if (lane_we) begin
                fwd_mem[head.idx] <= head.val;
            end
            if (rd_en && !dec_next) begin
                fwd_q_reg <= fwd_mem[fwd_addr];
            end
        end

        // inverse table: written by loads, read during decrypt
        always_ff @(posedge aclk) begin
            if (lane_we) begin
                inv_mem[head.val] <= head.idx;
            end
            if (rd_en && dec_next) begin
                inv_q_reg <= inv_mem[inv_addr];
            end
        end

        assign fwd_word[Hi -: srbc_pkg::BYTE_W] = fwd_q_reg;
        assign inv_word[Hi -: srbc_pkg::BYTE_W] = inv_q_reg;
    end

    // sequencer: pop, load or run the rounds, hand off the result
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dec_next   = dec_reg;
        pop        = 1'b0;
        tbl_we     = 1'b0;
        rd_en      = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            srbc_pkg::ST_IDLE: begin
                if (q_stat.not_empty) begin
                    pop = 1'b1;
                    case (head.op)
                        srbc_pkg::OP_LOAD: begin
                            tbl_we = 1'b1;
                        end
                        srbc_pkg::OP_ENC: begin
                            dec_next   = 1'b0;
                            rd_en      = 1'b1;
                            cnt_next   = srbc_pkg::ROUND_W'(1);
                            state_next = srbc_pkg::ST_RUN;
                        end
                        srbc_pkg::OP_DEC: begin
                            dec_next   = 1'b1;
                            rd_en      = 1'b1;
                            cnt_next   = srbc_pkg::ROUND_W'(1);
                            state_next = srbc_pkg::ST_RUN;
                        end
                        default: begin
                            tbl_we = 1'b0;
                        end
                    endcase
                end
            end
            srbc_pkg::ST_RUN: begin
                if (cnt_reg == srbc_pkg::ROUND_W'(srbc_pkg::ROUND_COUNT)) begin
                    if (!out_valid_reg || m_ready) begin
                        load_out   = 1'b1;
                        state_next = srbc_pkg::ST_IDLE;
                    end
                end else begin
                    rd_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = srbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srbc_pkg::ST_IDLE;
            cnt_reg   <= '0;
            dec_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dec_reg   <= dec_next;
        end
    end

    // result register
    always_comb begin
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_block_reg <= cur_blk;
            out_dec_reg   <= dec_reg;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_result_block       = out_block_reg;
    assign m_result_was_decrypt = out_dec_reg;
    assign stat.pop             = pop;
    assign stat.done            = load_out;

endmodule

>>> rtl/sbox_rotate_block_cipher_top.sv
// top level of the substitution-rotation block cipher
// Usage:
//   Input channel (s_valid/s_ready) takes one item per handshake: a table load
//   (req_type 0), an encrypt (1) or a decrypt (2); code 3 is taken and dropped.
//   A load writes the forward entry and the matching inverse entry of one byte
//   lane; it gives no result. Encrypt and decrypt give one result item on the
//   m_valid/m_ready channel, flagged by m_result_was_decrypt. The user writes
//   cipher_key via cfg_we/cfg_wdata only when idle; the block does not check it.
// Timing:
//   Each round is one read of the eight lane tables, one round per cycle, so an
//   encrypt or decrypt holds the engine for all ROUND_COUNT rounds, and the
//   engine takes no new item until that result is in the output register. A
//   load writes its table entries without running any rounds.
//   A two-item queue separates the input from the engine, so items are still
//   taken while a block is in flight, until the queue is full.
// Reset: queue, sequencer and result valid clear and the key goes to zero;
//   table contents are undefined until loaded.
// Stall: a finished result waits in the output register; the engine holds its
//   last round until that register is free, and the queue then fills.
`timescale 1ns / 1ps
`include "sbox_rotate_block_cipher_top_defines.svh"

module sbox_rotate_block_cipher_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [srbc_pkg::BLOCK_W-1:0]      cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic [srbc_pkg::SEL_W-1:0]        s_table_select,
    input  logic [srbc_pkg::BYTE_W-1:0]       s_entry_index,
    input  logic [srbc_pkg::BYTE_W-1:0]       s_entry_value,
    input  logic [srbc_pkg::BLOCK_W-1:0]      s_data_block,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [srbc_pkg::BLOCK_W-1:0]      m_result_block,
    output logic                              m_result_was_decrypt
);

    logic [srbc_pkg::BLOCK_W-1:0] key_reg;
    logic                         q_push;
    srbc_pkg::q_item_t            q_item;
    srbc_pkg::q_item_t            q_head;
    srbc_pkg::q_stat_t            q_stat;
    srbc_pkg::eng_stat_t          eng_stat;

    // key register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_we) begin
            key_reg <= cfg_wdata;
        end
    end

    srbc_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_table_select (s_table_select),
        .s_entry_index  (s_entry_index),
        .s_entry_value  (s_entry_value),
        .s_data_block   (s_data_block),
        .q_stat         (q_stat),
        .q_push         (q_push),
        .q_item         (q_item)
    );

    srbc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .pop       (eng_stat.pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    srbc_engine u_engine (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .key                  (key_reg),
        .head                 (q_head),
        .q_stat               (q_stat),
        .stat                 (eng_stat),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_result_block       (m_result_block),
        .m_result_was_decrypt (m_result_was_decrypt)
    );

    // checks
    `SRBC_ASSERT_RST(a_level_bound, q_stat.level <= srbc_pkg::LEVEL_W'(srbc_pkg::QUEUE_DEPTH), "queue level beyond depth")
    `SRBC_ASSERT_RST(a_pop_nonempty, eng_stat.pop |-> q_stat.not_empty, "engine popped an empty queue")
    `SRBC_ASSERT_RST(a_valid_from_done, $rose(m_valid) |-> $past(eng_stat.done), "result valid without engine finish")
    `SRBC_ASSERT_ANY(a_reset_clears, !aresetn |=> !m_valid, "result valid right after reset")

endmodule
